// ===== rtl/lkvc_pkg.sv =====
// Package for the LRU key/value cache: request codes, fixed field widths
// and the update control bundle. No dependencies.
`default_nettype none

package lkvc_pkg;

  localparam int FIELD_BITS     = 32;
  localparam int CFG_BITS       = 5;
  localparam int COUNT_OUT_BITS = 5;
  localparam logic [CFG_BITS-1:0] CAPACITY_RESET = 5'd16;

  typedef enum logic [1:0] {
    REQ_GET      = 2'd0,
    REQ_PUT      = 2'd1,
    REQ_CONTAINS = 2'd2,
    REQ_CLEAR    = 2'd3
  } req_kind_t;

  typedef struct packed {
    logic clear;
    logic promote;
    logic write_hit;
    logic insert;
    logic evict;
  } upd_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/lru_key_value_cache_top.sv =====
// Top level of the fully associative key/value cache with LRU replacement.
// Depends on lkvc_pkg, lkvc_lookup and lkvc_store.
//
// A request (req_type, lookup_key, write_value) is taken at a rising edge
// with start high and busy low. It is held in an input register while
// every entry compares its key in parallel and the new ranks, slot and
// count are formed; the next edge updates the store and loads the result
// register. done is a one-cycle strobe per request, registered together
// with found, read_value, entry_count and evicted. The receiver cannot
// stall, so nothing is ever held back.
// A new request can be taken every cycle while busy is low; the rate is
// one per clock, set by the single pass through the compare and rank logic.
// The capacity register is written by a cfg_valid/cfg_ready transfer; it
// is ready while no request sits in the input register, and a write empties
// the store. busy is high only in the cycle of such a write.
// Reset empties the store, sets the capacity to 16 and clears done.
`default_nettype none

module lru_key_value_cache_top
  import lkvc_pkg::*;
#(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            req_type,
  input  logic [FIELD_BITS-1:0] lookup_key,
  input  logic [FIELD_BITS-1:0] write_value,
  output logic                  done,
  output logic                  found,
  output logic [FIELD_BITS-1:0] read_value,
  output logic [COUNT_OUT_BITS-1:0] entry_count,
  output logic                  evicted,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_BITS-1:0]   cfg_data
);

  localparam int KW = (KEY_BITS < FIELD_BITS) ? KEY_BITS : FIELD_BITS;
  localparam int VW = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
  localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  logic               req_valid;
  req_kind_t          req_kind;
  logic [KW-1:0]      req_key;
  logic [VW-1:0]      req_value;
  logic [CFG_BITS-1:0] capacity;
  logic [CW-1:0]      cap_eff;
  logic               cfg_write;

  logic [ENTRIES-1:0] valid;
  logic [KW-1:0]      keys    [ENTRIES];
  logic [VW-1:0]      values  [ENTRIES];
  logic [RW-1:0]      ranks   [ENTRIES];
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] younger_vec;
  logic [ENTRIES-1:0] lru_vec;
  logic [ENTRIES-1:0] slot_vec;
  logic               hit_any;
  logic               full;
  logic [VW-1:0]      hit_value;
  upd_ctrl_t          ctrl;

  assign cfg_ready = !req_valid;
  assign cfg_write = cfg_valid && cfg_ready;
  assign busy      = cfg_write;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      capacity  <= CAPACITY_RESET;
    end else begin
      req_valid <= start && !busy;
      if (cfg_write) begin
        capacity <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_kind  <= req_kind_t'(req_type);
      req_key   <= lookup_key[KW-1:0];
      req_value <= write_value[VW-1:0];
    end
  end

  always_comb begin
    priority if (capacity == '0) begin
      cap_eff = CW'(1);
    end else if (32'(capacity) > ENTRIES) begin
      cap_eff = CW'(ENTRIES);
    end else begin
      cap_eff = CW'(capacity);
    end
  end

  lkvc_lookup #(
    .ENTRIES(ENTRIES), .KW(KW), .VW(VW), .RW(RW), .CW(CW)
  ) u_lookup (
    .valid      (valid),
    .keys       (keys),
    .values     (values),
    .ranks      (ranks),
    .count      (count),
    .cap_eff    (cap_eff),
    .key        (req_key),
    .hit_vec    (hit_vec),
    .younger_vec(younger_vec),
    .lru_vec    (lru_vec),
    .slot_vec   (slot_vec),
    .hit_any    (hit_any),
    .full       (full),
    .hit_value  (hit_value)
  );

  always_comb begin
    ctrl       = '0;
    ctrl.clear = cfg_write || (req_valid && (req_kind == REQ_CLEAR));
    if (req_valid) begin
      unique case (req_kind)
        REQ_GET: begin
          ctrl.promote = hit_any;
        end
        REQ_PUT: begin
          ctrl.promote   = hit_any;
          ctrl.write_hit = hit_any;
          ctrl.insert    = !hit_any;
          ctrl.evict     = !hit_any && full;
        end
        REQ_CONTAINS, REQ_CLEAR: begin
          ctrl.promote = 1'b0;
        end
        default: begin
          ctrl.promote = 1'b0;
        end
      endcase
    end
  end

  lkvc_store #(
    .ENTRIES(ENTRIES), .KW(KW), .VW(VW), .RW(RW), .CW(CW)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .hit_vec    (hit_vec),
    .younger_vec(younger_vec),
    .lru_vec    (lru_vec),
    .slot_vec   (slot_vec),
    .key        (req_key),
    .value      (req_value),
    .valid      (valid),
    .keys       (keys),
    .values     (values),
    .ranks      (ranks),
    .count      (count),
    .count_next (count_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      found       <= hit_any && (req_kind != REQ_CLEAR);
      read_value  <= (hit_any && (req_kind == REQ_GET)) ? FIELD_BITS'(hit_value) : '0;
      entry_count <= COUNT_OUT_BITS'(count_next);
      evicted     <= ctrl.evict;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lkvc_lookup.sv =====
// Parallel key compare, recency decode and free slot choice for the cache.
// Depends on lkvc_pkg.
`default_nettype none

module lkvc_lookup
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int KW      = 32,
  parameter int VW      = 32,
  parameter int RW      = 4,
  parameter int CW      = 5
) (
  input  logic [ENTRIES-1:0] valid,
  input  logic [KW-1:0]      keys    [ENTRIES],
  input  logic [VW-1:0]      values  [ENTRIES],
  input  logic [RW-1:0]      ranks   [ENTRIES],
  input  logic [CW-1:0]      count,
  input  logic [CW-1:0]      cap_eff,
  input  logic [KW-1:0]      key,
  output logic [ENTRIES-1:0] hit_vec,
  output logic [ENTRIES-1:0] younger_vec,
  output logic [ENTRIES-1:0] lru_vec,
  output logic [ENTRIES-1:0] slot_vec,
  output logic               hit_any,
  output logic               full,
  output logic [VW-1:0]      hit_value
);

  logic [RW-1:0]      hit_rank;
  logic [ENTRIES-1:0] free_vec;

  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid[i] && (keys[i] == key);
      lru_vec[i] = valid[i] && (CW'(ranks[i]) == (count - CW'(1)));
      hit_rank   = hit_rank | (ranks[i] & {RW{hit_vec[i]}});
      hit_value  = hit_value | (values[i] & {VW{hit_vec[i]}});
    end
    for (int i = 0; i < ENTRIES; i++) begin
      younger_vec[i] = valid[i] && !hit_vec[i] && (ranks[i] < hit_rank);
    end
  end

  assign hit_any  = |hit_vec;
  assign full     = (count >= cap_eff);
  assign free_vec = ~valid | (full ? lru_vec : '0);
  assign slot_vec = free_vec & (~free_vec + ENTRIES'(1));

endmodule

`default_nettype wire

// ===== rtl/lkvc_store.sv =====
// Entry storage of the cache: keys, values, valid bits, recency ranks and
// the entry count, updated from one control bundle. Depends on lkvc_pkg.
`default_nettype none

module lkvc_store
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int KW      = 32,
  parameter int VW      = 32,
  parameter int RW      = 4,
  parameter int CW      = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  upd_ctrl_t          ctrl,
  input  logic [ENTRIES-1:0] hit_vec,
  input  logic [ENTRIES-1:0] younger_vec,
  input  logic [ENTRIES-1:0] lru_vec,
  input  logic [ENTRIES-1:0] slot_vec,
  input  logic [KW-1:0]      key,
  input  logic [VW-1:0]      value,
  output logic [ENTRIES-1:0] valid,
  output logic [KW-1:0]      keys    [ENTRIES],
  output logic [VW-1:0]      values  [ENTRIES],
  output logic [RW-1:0]      ranks   [ENTRIES],
  output logic [CW-1:0]      count,
  output logic [CW-1:0]      count_next
);

  always_comb begin
    priority if (ctrl.clear) begin
      count_next = '0;
    end else if (ctrl.insert && !ctrl.evict) begin
      count_next = count + CW'(1);
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (ctrl.insert && slot_vec[i]) begin
        keys[i]   <= key;
        values[i] <= value;
      end else if (ctrl.write_hit && hit_vec[i]) begin
        values[i] <= value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid <= '0;
      count <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        ranks[i] <= '0;
      end
    end else begin
      count <= count_next;
      for (int i = 0; i < ENTRIES; i++) begin
        if (ctrl.promote) begin
          if (hit_vec[i]) begin
            ranks[i] <= '0;
          end else if (younger_vec[i]) begin
            ranks[i] <= ranks[i] + RW'(1);
          end
        end else if (ctrl.insert) begin
          if (slot_vec[i]) begin
            valid[i] <= 1'b1;
            ranks[i] <= '0;
          end else if (ctrl.evict && lru_vec[i]) begin
            valid[i] <= 1'b0;
            ranks[i] <= '0;
          end else if (valid[i]) begin
            ranks[i] <= ranks[i] + RW'(1);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lkvc_checker.sv =====
// Port-level checker for the LRU key/value cache and its bind to the top
// level. Depends on lkvc_pkg and lru_key_value_cache_top.
`default_nettype none

module lkvc_checker
  import lkvc_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      done,
  input logic                      found,
  input logic [FIELD_BITS-1:0]     read_value,
  input logic                      evicted,
  input logic                      cfg_valid,
  input logic                      cfg_ready
);

  a_done_follows_transfer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("request transfer did not produce a result two cycles later");

  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without a matching request transfer");

  a_evict_is_miss: assert property (@(posedge clk) disable iff (rst)
    (done && evicted) |-> !found)
    else $error("eviction reported on a request that hit");

  a_miss_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (read_value == '0))
    else $error("nonzero read value on a miss");

  a_cfg_when_idle: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> !done)
    else $error("configuration transfer taken while a request was in flight");

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .found     (found),
  .read_value(read_value),
  .evicted   (evicted),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

`default_nettype wire

// ===== sim/lru_cache_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the LRU key/value cache: follows request, result and
// capacity transfers, keeps its own copy of the cache and compares results.
// Depends on lkvc_pkg.
module lru_cache_checker
  import lkvc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic [1:0]                req_type,
  input  logic [FIELD_BITS-1:0]     lookup_key,
  input  logic [FIELD_BITS-1:0]     write_value,
  input  logic                      done,
  input  logic                      found,
  input  logic [FIELD_BITS-1:0]     read_value,
  input  logic [COUNT_OUT_BITS-1:0] entry_count,
  input  logic                      evicted,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_BITS-1:0]       cfg_data,
  output int                        errors,
  output int                        outstanding
);

  localparam int SLOTS = 16;

  typedef struct packed {
    logic                      found;
    logic [FIELD_BITS-1:0]     read_value;
    logic [COUNT_OUT_BITS-1:0] entry_count;
    logic                      evicted;
  } reply_t;

  logic [FIELD_BITS-1:0]     slot_key [SLOTS];
  logic [FIELD_BITS-1:0]     slot_value [SLOTS];
  logic                      slot_valid [SLOTS];
  logic [3:0]                slot_rank [SLOTS];
  logic [COUNT_OUT_BITS-1:0] used;
  logic [CFG_BITS-1:0]       capacity;
  reply_t                    expected_replies [$];
  reply_t                    want;

  function automatic void clear_slots();
    int i;
    for (i = 0; i < SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_rank[i] = '0;
    end
    used = '0;
  endfunction

  function automatic reply_t apply_request(input req_kind_t kind,
                                           input logic [FIELD_BITS-1:0] key,
                                           input logic [FIELD_BITS-1:0] value);
    reply_t     r;
    int         i;
    int         hit;
    int         limit;
    logic [3:0] hit_rank;
    logic       taken;
    r = '0;
    if (kind == REQ_CLEAR) begin
      clear_slots();
    end else begin
      hit = -1;
      for (i = 0; i < SLOTS; i++) begin
        if (hit < 0 && slot_valid[i] && slot_key[i] == key) hit = i;
      end
      r.found = (hit >= 0);
      if (hit >= 0 && (kind == REQ_GET || kind == REQ_PUT)) begin
        if (kind == REQ_GET) begin
          r.read_value = slot_value[hit];
        end else begin
          slot_value[hit] = value;
        end
        hit_rank = slot_rank[hit];
        for (i = 0; i < SLOTS; i++) begin
          if (slot_valid[i] && i != hit && slot_rank[i] < hit_rank) slot_rank[i]++;
        end
        slot_rank[hit] = '0;
      end else if (kind == REQ_PUT) begin
        limit = (capacity == 0) ? 1 : ((int'(capacity) > SLOTS) ? SLOTS : int'(capacity));
        if (int'(used) >= limit) begin
          taken = 1'b0;
          for (i = 0; i < SLOTS; i++) begin
            if (!taken && slot_valid[i] && int'(slot_rank[i]) == int'(used) - 1) begin
              slot_valid[i] = 1'b0;
              slot_rank[i] = '0;
              taken = 1'b1;
            end
          end
          used--;
          r.evicted = 1'b1;
        end
        for (i = 0; i < SLOTS; i++) begin
          if (slot_valid[i]) slot_rank[i]++;
        end
        taken = 1'b0;
        for (i = 0; i < SLOTS; i++) begin
          if (!taken && !slot_valid[i]) begin
            slot_valid[i] = 1'b1;
            slot_key[i] = key;
            slot_value[i] = value;
            slot_rank[i] = '0;
            taken = 1'b1;
          end
        end
        used++;
      end
    end
    r.entry_count = used;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      capacity = CAPACITY_RESET;
      clear_slots();
      expected_replies.delete();
    end else begin
      if (done) begin
        if (expected_replies.size() == 0) begin
          errors++;
          $display("%0t: result transfer with none expected", $time);
        end else begin
          want = expected_replies.pop_front();
          if (found !== want.found) begin
            errors++;
            $display("%0t: found expected %0d actual %0d", $time, want.found, found);
          end
          if (read_value !== want.read_value) begin
            errors++;
            $display("%0t: read_value expected %08h actual %08h", $time,
                     want.read_value, read_value);
          end
          if (entry_count !== want.entry_count) begin
            errors++;
            $display("%0t: entry_count expected %0d actual %0d", $time,
                     want.entry_count, entry_count);
          end
          if (evicted !== want.evicted) begin
            errors++;
            $display("%0t: evicted expected %0d actual %0d", $time, want.evicted, evicted);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        capacity = cfg_data;
        clear_slots();
      end
      if (start && !busy) begin
        expected_replies = {expected_replies,
                            apply_request(req_kind_t'(req_type), lookup_key, write_value)};
      end
    end
    outstanding = expected_replies.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the LRU key/value cache: drives directed and random
// requests and capacity writes, and gives the verdict from lru_cache_checker.
// Depends on lkvc_pkg, lru_key_value_cache_top and lru_cache_checker.
module tb_top;
  import lkvc_pkg::*;

  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 95;
  localparam int POOL_MAX = 32;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic [1:0]                req_type = '0;
  logic [FIELD_BITS-1:0]     lookup_key = '0;
  logic [FIELD_BITS-1:0]     write_value = '0;
  logic                      done;
  logic                      found;
  logic [FIELD_BITS-1:0]     read_value;
  logic [COUNT_OUT_BITS-1:0] entry_count;
  logic                      evicted;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_BITS-1:0]       cfg_data = '0;
  int                        errors;
  int                        outstanding;

  logic [FIELD_BITS-1:0] key_pool [POOL_MAX];
  logic [CFG_BITS-1:0]   phase_caps [PHASES] = '{5'd16, 5'd1, 5'd31, 5'd3, 5'd0,
                                                 5'd8, 5'd2, 5'd17, 5'd5, 5'd12};

  lru_key_value_cache_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .lookup_key(lookup_key), .write_value(write_value), .done(done), .found(found),
    .read_value(read_value), .entry_count(entry_count), .evicted(evicted),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  lru_cache_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .lookup_key(lookup_key), .write_value(write_value), .done(done), .found(found),
    .read_value(read_value), .entry_count(entry_count), .evicted(evicted),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_req(input req_kind_t kind, input logic [FIELD_BITS-1:0] key,
                          input logic [FIELD_BITS-1:0] value);
    @(negedge clk);
    start <= 1'b1;
    req_type <= kind;
    lookup_key <= key;
    write_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_BITS-1:0] cap);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int                    p;
    int                    n;
    int                    pick;
    int                    pool_size;
    int                    limit;
    logic                  idle_on;
    req_kind_t             kind;
    logic [FIELD_BITS-1:0] key;

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Reset capacity: misses on an empty cache, extreme keys and values,
    // update of a present key, contains without promotion, clear.
    send_req(REQ_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_req(REQ_CONTAINS, 32'hFFFF_FFFF, 32'h0);
    send_req(REQ_PUT, 32'h0000_0000, 32'h0000_0000);
    send_req(REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(REQ_GET, 32'hFFFF_FFFF, 32'h0);
    send_req(REQ_CONTAINS, 32'h0000_0000, 32'h1234_5678);
    send_req(REQ_PUT, 32'h0000_0000, 32'h5A5A_A5A5);
    send_req(REQ_GET, 32'h0000_0000, 32'h0);
    send_req(REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(REQ_GET, 32'hFFFF_FFFF, 32'h0);

    // A capacity of zero behaves as one: the second insert evicts the first.
    write_capacity(5'd0);
    send_req(REQ_PUT, 32'h0000_00A1, 32'h1111_1111);
    send_req(REQ_PUT, 32'h0000_00B2, 32'h2222_2222);
    send_req(REQ_GET, 32'h0000_00A1, 32'h0);
    send_req(REQ_GET, 32'h0000_00B2, 32'h0);

    // With two entries a get promotes, so the other key is the victim.
    write_capacity(5'd2);
    send_req(REQ_PUT, 32'h0000_00A1, 32'h3333_3333);
    send_req(REQ_PUT, 32'h0000_00B2, 32'h4444_4444);
    send_req(REQ_GET, 32'h0000_00A1, 32'h0);
    send_req(REQ_PUT, 32'h0000_00C3, 32'h5555_5555);
    send_req(REQ_CONTAINS, 32'h0000_00B2, 32'h0);
    send_req(REQ_CONTAINS, 32'h0000_00A1, 32'h0);
    send_req(REQ_PUT, 32'h0000_00D4, 32'h6666_6666);
    send_req(REQ_GET, 32'h0000_00A1, 32'h0);

    for (p = 0; p < PHASES; p++) begin
      write_capacity(phase_caps[p]);
      limit = (phase_caps[p] == 0) ? 1 : ((phase_caps[p] > 16) ? 16 : int'(phase_caps[p]));
      pool_size = limit + $urandom_range(1, 8);
      for (n = 0; n < pool_size; n++) key_pool[n] = $urandom;
      idle_on = (p % 3 != 1) && (p != PHASES - 1);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (idle_on && $urandom_range(0, 99) < 20) hold_off($urandom_range(1, 8));
        if (n == 47 && p != PHASES - 1) drain();
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          kind = REQ_GET;
        end else if (pick < 75) begin
          kind = REQ_PUT;
        end else if (pick < 97) begin
          kind = REQ_CONTAINS;
        end else begin
          kind = REQ_CLEAR;
        end
        if ($urandom_range(0, 99) < 92) begin
          key = key_pool[$urandom_range(0, pool_size - 1)];
        end else begin
          key = $urandom;
        end
        send_req(kind, key, $urandom);
      end
    end

    drain();
    repeat (4) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
